### rtl/core/dssc_pkg.sv
`default_nettype none

package dssc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  SVC_SESSION      = 8'h10;
    localparam logic [7:0]  SVC_SECURITY     = 8'h27;
    localparam logic [7:0]  SESS_DEFAULT     = 8'h01;
    localparam logic [7:0]  SESS_PROGRAMMING = 8'h02;
    localparam logic [7:0]  SESS_EXTENDED    = 8'h03;
    localparam logic [7:0]  SESS_SAFETY      = 8'h04;
    localparam logic [7:0]  LEN_SESSION      = 8'd2;
    localparam logic [7:0]  LEN_SECURITY_MIN = 8'd2;
    localparam logic [7:0]  LEN_KEY_MIN      = 8'd6;
    localparam logic [31:0] KEY_MASK         = 32'h1234_5678;
    localparam logic [7:0]  FAIL_CNT_MAX     = 8'hFF;

    localparam logic [15:0] RST_SESSION_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_LOCKOUT         = 16'd10000;
    localparam logic [7:0]  RST_MAX_FAILURES    = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SESSION_TIMEOUT = 3'd0,
        CFG_LOCKOUT         = 3'd1,
        CFG_MAX_FAILURES    = 3'd2,
        CFG_ENABLE_PROG     = 3'd3,
        CFG_ENABLE_EXT      = 3'd4,
        CFG_ENABLE_SAFETY   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_TICK    = 3'd1,
        OP_SESSION = 3'd2,
        OP_SEED    = 3'd3,
        OP_KEY     = 3'd4
    } t_op;

    typedef struct packed {
        logic [15:0] session_timeout;
        logic [15:0] lockout;
        logic [7:0]  max_failures;
        logic        enable_prog;
        logic        enable_ext;
        logic        enable_safety;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic        key_long;
        logic [7:0]  sub;
        logic [31:0] data;
    } t_cmd;

    typedef struct packed {
        logic       accepted;
        logic [7:0] current_session;
        logic       is_locked;
        logic [6:0] security_level;
    } t_res;

endpackage

`default_nettype wire

### rtl/core/dssc_queue.sv
`default_nettype none

module dssc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dssc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/dssc_front.sv
`default_nettype none

module dssc_front (
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_request_length,
    input  wire logic [7:0]    i_service_code,
    input  wire logic [7:0]    i_sub_byte,
    input  wire logic [31:0]   i_key_value,
    input  wire logic [31:0]   i_fresh_seed,
    input  wire dssc_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_full,
    output logic               o_cmd_push,
    output dssc_pkg::t_cmd     o_cmd
);

    logic sess_allowed;

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    always_comb begin
        case (i_sub_byte)
            dssc_pkg::SESS_PROGRAMMING: sess_allowed = i_cfg.enable_prog;
            dssc_pkg::SESS_EXTENDED:    sess_allowed = i_cfg.enable_ext;
            dssc_pkg::SESS_SAFETY:      sess_allowed = i_cfg.enable_safety;
            default:                    sess_allowed = 1'b1;
        endcase
    end

    always_comb begin
        o_cmd.op       = dssc_pkg::OP_NONE;
        o_cmd.key_long = (i_request_length >= dssc_pkg::LEN_KEY_MIN);
        o_cmd.sub      = i_sub_byte;
        o_cmd.data     = i_sub_byte[0] ? i_fresh_seed : i_key_value;
        if (!i_mode) begin
            o_cmd.op = dssc_pkg::OP_TICK;
        end else if (i_service_code == dssc_pkg::SVC_SESSION) begin
            if (i_request_length == dssc_pkg::LEN_SESSION && sess_allowed) begin
                o_cmd.op = dssc_pkg::OP_SESSION;
            end
        end else if (i_service_code == dssc_pkg::SVC_SECURITY) begin
            if (i_request_length >= dssc_pkg::LEN_SECURITY_MIN) begin
                o_cmd.op = i_sub_byte[0] ? dssc_pkg::OP_SEED : dssc_pkg::OP_KEY;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/dssc_back.sv
`default_nettype none

module dssc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dssc_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire dssc_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output dssc_pkg::t_res      o_res
);

    logic [7:0]  r_session;
    logic        r_running;
    logic        r_locked;
    logic [6:0]  r_level;
    logic [31:0] r_seed;
    logic [7:0]  r_fail;
    logic [15:0] r_sess_rem;
    logic [15:0] r_lock_rem;

    logic [7:0]  n_session;
    logic        n_running;
    logic        n_locked;
    logic [6:0]  n_level;
    logic [31:0] n_seed;
    logic [7:0]  n_fail;
    logic [15:0] n_sess_rem;
    logic [15:0] n_lock_rem;

    logic        go;
    logic        acc;
    logic [15:0] sess_dec;
    logic [15:0] lock_dec;
    logic [7:0]  fail_inc;

    assign go         = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = go;
    assign o_res_push = go;
    assign sess_dec   = (r_sess_rem != '0) ? r_sess_rem - 16'd1 : r_sess_rem;
    assign lock_dec   = (r_lock_rem != '0) ? r_lock_rem - 16'd1 : r_lock_rem;
    assign fail_inc   = (r_fail != dssc_pkg::FAIL_CNT_MAX) ? r_fail + 8'd1 : r_fail;

    always_comb begin
        n_session  = r_session;
        n_running  = r_running;
        n_locked   = r_locked;
        n_level    = r_level;
        n_seed     = r_seed;
        n_fail     = r_fail;
        n_sess_rem = r_sess_rem;
        n_lock_rem = r_lock_rem;
        acc        = 1'b0;
        if (go) begin
            case (i_cmd.op)
                dssc_pkg::OP_TICK: begin
                    n_sess_rem = sess_dec;
                    n_lock_rem = lock_dec;
                    if (r_running && sess_dec == '0) begin
                        n_session = dssc_pkg::SESS_DEFAULT;
                        n_running = 1'b0;
                        n_locked  = 1'b1;
                        n_level   = '0;
                    end
                    if (r_fail != '0 && lock_dec == '0) begin
                        n_fail = '0;
                    end
                end
                dssc_pkg::OP_SESSION: begin
                    n_session  = i_cmd.sub;
                    n_running  = 1'b1;
                    n_sess_rem = i_cfg.session_timeout;
                    acc        = 1'b1;
                end
                dssc_pkg::OP_SEED: begin
                    if (r_fail < i_cfg.max_failures) begin
                        n_seed = i_cmd.data;
                        acc    = 1'b1;
                    end
                end
                dssc_pkg::OP_KEY: begin
                    if (i_cmd.key_long && i_cmd.data == (r_seed ^ dssc_pkg::KEY_MASK)) begin
                        n_locked = 1'b0;
                        n_level  = i_cmd.sub[7:1];
                        n_fail   = '0;
                        acc      = 1'b1;
                    end else begin
                        n_fail = fail_inc;
                        if (fail_inc >= i_cfg.max_failures) begin
                            n_lock_rem = i_cfg.lockout;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res.accepted        = acc;
        o_res.current_session = n_session;
        o_res.is_locked       = n_locked;
        o_res.security_level  = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session  <= dssc_pkg::SESS_DEFAULT;
            r_running  <= 1'b0;
            r_locked   <= 1'b1;
            r_level    <= '0;
            r_seed     <= '0;
            r_fail     <= '0;
            r_sess_rem <= '0;
            r_lock_rem <= '0;
        end else begin
            r_session  <= n_session;
            r_running  <= n_running;
            r_locked   <= n_locked;
            r_level    <= n_level;
            r_seed     <= n_seed;
            r_fail     <= n_fail;
            r_sess_rem <= n_sess_rem;
            r_lock_rem <= n_lock_rem;
        end
    end

    a_locked_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> (r_level == '0))
        else $error("locked access holds a non-zero level");

    a_idle_default_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_session == dssc_pkg::SESS_DEFAULT))
        else $error("stopped session is not the default session");

    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_fail != $past(r_fail))
            |-> (r_fail == '0 || r_fail == $past(r_fail) + 8'd1))
        else $error("failure count moved by more than one");

endmodule

`default_nettype wire

### rtl/core/diag_session_security_control.sv
// Accepted items pass the command queue, then the back end, then the result queue to the outputs.
// Throughput: one item per cycle, with push and pop both free to stall.
// The command queue and the result queue decouple classification from execution.
// Reset is synchronous and active low; it empties both queues, restores the
// configuration defaults and returns to the default session, locked, no failures.
`default_nettype none

module diag_session_security_control #(
    parameter int QUEUE_DEPTH = dssc_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [dssc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dssc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          i_mode,
    input  wire logic [7:0]                    i_request_length,
    input  wire logic [7:0]                    i_service_code,
    input  wire logic [7:0]                    i_sub_byte,
    input  wire logic [31:0]                   i_key_value,
    input  wire logic [31:0]                   i_fresh_seed,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               o_accepted,
    output logic [7:0]                         o_current_session,
    output logic                               o_is_locked,
    output logic [6:0]                         o_security_level
);

    localparam int CMD_W = $bits(dssc_pkg::t_cmd);
    localparam int RES_W = $bits(dssc_pkg::t_res);

    dssc_pkg::t_cfg r_cfg;
    dssc_pkg::t_cmd fe_cmd;
    dssc_pkg::t_cmd q_cmd;
    dssc_pkg::t_res be_res;
    dssc_pkg::t_res q_res;

    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    logic res_push;
    logic res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.session_timeout <= dssc_pkg::RST_SESSION_TIMEOUT;
            r_cfg.lockout         <= dssc_pkg::RST_LOCKOUT;
            r_cfg.max_failures    <= dssc_pkg::RST_MAX_FAILURES;
            r_cfg.enable_prog     <= 1'b0;
            r_cfg.enable_ext      <= 1'b0;
            r_cfg.enable_safety   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (dssc_pkg::t_cfg_idx'(i_cfg_idx))
                dssc_pkg::CFG_SESSION_TIMEOUT: r_cfg.session_timeout <= i_cfg_wdata;
                dssc_pkg::CFG_LOCKOUT:         r_cfg.lockout         <= i_cfg_wdata;
                dssc_pkg::CFG_MAX_FAILURES:    r_cfg.max_failures    <= i_cfg_wdata[7:0];
                dssc_pkg::CFG_ENABLE_PROG:     r_cfg.enable_prog     <= i_cfg_wdata[0];
                dssc_pkg::CFG_ENABLE_EXT:      r_cfg.enable_ext      <= i_cfg_wdata[0];
                dssc_pkg::CFG_ENABLE_SAFETY:   r_cfg.enable_safety   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    dssc_front u_front (
        .i_push           (push),
        .o_full           (full),
        .i_mode           (i_mode),
        .i_request_length (i_request_length),
        .i_service_code   (i_service_code),
        .i_sub_byte       (i_sub_byte),
        .i_key_value      (i_key_value),
        .i_fresh_seed     (i_fresh_seed),
        .i_cfg            (r_cfg),
        .i_cmd_full       (cmd_full),
        .o_cmd_push       (cmd_push),
        .o_cmd            (fe_cmd)
    );

    dssc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (fe_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (q_cmd)
    );

    dssc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (be_res)
    );

    dssc_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (be_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_res)
    );

    assign o_accepted        = q_res.accepted;
    assign o_current_session = q_res.current_session;
    assign o_is_locked       = q_res.is_locked;
    assign o_security_level  = q_res.security_level;

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
    import dssc_pkg::*;

    localparam int  CLK_HALF    = 10;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  IDLE_PCT    = 29;
    localparam int  SETTLE      = 4;
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  len;
        logic [7:0]  svc;
        logic [7:0]  sub;
        logic [31:0] key;
        logic [31:0] seed;
    } t_diag_req;

    localparam int REQ_W = $bits(t_diag_req);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_mode = 1'b0;
    logic [7:0]            i_request_length = '0;
    logic [7:0]            i_service_code = '0;
    logic [7:0]            i_sub_byte = '0;
    logic [31:0]           i_key_value = '0;
    logic [31:0]           i_fresh_seed = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_accepted;
    logic [7:0]            o_current_session;
    logic                  o_is_locked;
    logic [6:0]            o_security_level;

    diag_session_security_control DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .push              (push),
        .full              (full),
        .i_mode            (i_mode),
        .i_request_length  (i_request_length),
        .i_service_code    (i_service_code),
        .i_sub_byte        (i_sub_byte),
        .i_key_value       (i_key_value),
        .i_fresh_seed      (i_fresh_seed),
        .empty             (empty),
        .pop               (pop),
        .o_accepted        (o_accepted),
        .o_current_session (o_current_session),
        .o_is_locked       (o_is_locked),
        .o_security_level  (o_security_level)
    );

    logic [15:0] cfg_timeout;
    logic [15:0] cfg_lockout;
    logic [7:0]  cfg_max_fail;
    logic        cfg_en_prog;
    logic        cfg_en_ext;
    logic        cfg_en_safety;

    logic [7:0]  sess_code;
    logic        sess_active;
    logic        locked;
    logic [6:0]  level;
    logic [31:0] seed_held;
    logic [7:0]  fail_cnt;
    logic [15:0] sess_left;
    logic [15:0] lock_left;

    t_res expected_status_q[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    logic steady = 1'b0;

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void reset_session_model();
        cfg_timeout   = RST_SESSION_TIMEOUT;
        cfg_lockout   = RST_LOCKOUT;
        cfg_max_fail  = RST_MAX_FAILURES;
        cfg_en_prog   = 1'b0;
        cfg_en_ext    = 1'b0;
        cfg_en_safety = 1'b0;
        sess_code     = SESS_DEFAULT;
        sess_active   = 1'b0;
        locked        = 1'b1;
        level         = '0;
        seed_held     = '0;
        fail_cnt      = '0;
        sess_left     = '0;
        lock_left     = '0;
    endfunction

    function automatic t_res apply_request(input t_diag_req r);
        t_res res;
        logic ok;
        ok = 1'b0;
        if (r.mode == MODE_TICK) begin
            if (sess_left != 0) sess_left = sess_left - 16'd1;
            if (lock_left != 0) lock_left = lock_left - 16'd1;
            if (sess_active && sess_left == 0) begin
                sess_code   = SESS_DEFAULT;
                sess_active = 1'b0;
                locked      = 1'b1;
                level       = '0;
            end
            if (fail_cnt != 0 && lock_left == 0) fail_cnt = '0;
        end else if (r.len != 0) begin
            if (r.svc == SVC_SESSION) begin
                if (r.len == LEN_SESSION) begin
                    case (r.sub)
                        SESS_PROGRAMMING: ok = cfg_en_prog;
                        SESS_EXTENDED:    ok = cfg_en_ext;
                        SESS_SAFETY:      ok = cfg_en_safety;
                        default:          ok = 1'b1;
                    endcase
                    if (ok) begin
                        sess_code   = r.sub;
                        sess_active = 1'b1;
                        sess_left   = cfg_timeout;
                    end
                end
            end else if (r.svc == SVC_SECURITY && r.len >= LEN_SECURITY_MIN) begin
                if (r.sub[0]) begin
                    if (fail_cnt < cfg_max_fail) begin
                        seed_held = r.seed;
                        ok = 1'b1;
                    end
                end else if (r.len >= LEN_KEY_MIN && r.key == (seed_held ^ KEY_MASK)) begin
                    locked   = 1'b0;
                    level    = r.sub[7:1];
                    fail_cnt = '0;
                    ok = 1'b1;
                end else begin
                    if (fail_cnt != FAIL_CNT_MAX) fail_cnt = fail_cnt + 8'd1;
                    if (fail_cnt >= cfg_max_fail) lock_left = cfg_lockout;
                end
            end
        end
        res.accepted        = ok;
        res.current_session = sess_code;
        res.is_locked       = locked;
        res.security_level  = level;
        return res;
    endfunction

    function automatic t_diag_req mk_req(input logic [7:0] len, input logic [7:0] svc,
                                         input logic [7:0] sub, input logic [31:0] key,
                                         input logic [31:0] seed);
        t_diag_req r;
        r.mode = MODE_REQUEST;
        r.len  = len;
        r.svc  = svc;
        r.sub  = sub;
        r.key  = key;
        r.seed = seed;
        return r;
    endfunction

    function automatic t_diag_req mk_tick();
        t_diag_req r;
        r = t_diag_req'(REQ_W'({$urandom, $urandom, $urandom}));
        r.mode = MODE_TICK;
        return r;
    endfunction

    function automatic t_diag_req random_request();
        t_diag_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            r = mk_tick();
        end else if (pick < 50) begin
            r = mk_req(LEN_SESSION, SVC_SESSION, 8'($urandom_range(1, 4)), $urandom, $urandom);
            if ($urandom_range(0, 4) == 0) r.sub = 8'($urandom);
        end else if (pick < 63) begin
            r = mk_req(8'($urandom_range(2, 255)), SVC_SECURITY,
                       {7'($urandom), 1'b1}, $urandom, $urandom);
        end else if (pick < 78) begin
            r = mk_req(8'($urandom_range(6, 255)), SVC_SECURITY,
                       {7'($urandom), 1'b0}, seed_held ^ KEY_MASK, $urandom);
        end else if (pick < 88) begin
            r = mk_req(8'($urandom_range(2, 255)), SVC_SECURITY,
                       {7'($urandom), 1'b0}, $urandom, $urandom);
            if ($urandom_range(0, 1) == 0) r.key = seed_held ^ KEY_MASK;
        end else begin
            r = t_diag_req'(REQ_W'({$urandom, $urandom, $urandom}));
            if ($urandom_range(0, 1) == 0) r.svc = $urandom_range(0, 1) ? SVC_SESSION
                                                                         : SVC_SECURITY;
        end
        return r;
    endfunction

    task automatic send_item(input t_diag_req r);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push             <= 1'b1;
        i_mode           <= r.mode;
        i_request_length <= r.len;
        i_service_code   <= r.svc;
        i_sub_byte       <= r.sub;
        i_key_value      <= r.key;
        i_fresh_seed     <= r.seed;
        do @(posedge i_clk); while (full);
        expected_status_q.push_back(apply_request(r));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SESSION_TIMEOUT: cfg_timeout   = value;
            CFG_LOCKOUT:         cfg_lockout   = value;
            CFG_MAX_FAILURES:    cfg_max_fail  = value[7:0];
            CFG_ENABLE_PROG:     cfg_en_prog   = value[0];
            CFG_ENABLE_EXT:      cfg_en_ext    = value[0];
            CFG_ENABLE_SAFETY:   cfg_en_safety = value[0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result item arrived with none expected");
            end else begin
                want = expected_status_q.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                check_field("current_session", 32'(want.current_session),
                            32'(o_current_session));
                check_field("is_locked", 32'(want.is_locked), 32'(o_is_locked));
                check_field("security_level", 32'(want.security_level),
                            32'(o_security_level));
            end
        end
        pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic test_session_control();
        send_item(mk_tick());
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_PROGRAMMING, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_EXTENDED, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_SAFETY, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_DEFAULT, 32'h0, 32'h0));
        send_item(mk_req(8'd0, SVC_SESSION, SESS_DEFAULT, 32'h0, 32'h0));
        send_item(mk_req(8'd3, SVC_SESSION, SESS_EXTENDED, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, 8'h22, SESS_EXTENDED, 32'h0, 32'h0));
        send_item(mk_req(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        write_reg(CFG_ENABLE_PROG, 16'd1);
        write_reg(CFG_ENABLE_EXT, 16'd1);
        write_reg(CFG_ENABLE_SAFETY, 16'd1);
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_PROGRAMMING, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_EXTENDED, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_SAFETY, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, 8'h00, 32'h0, 32'h0));
        send_item(mk_req(LEN_SESSION, SVC_SESSION, 8'hFF, 32'h0, 32'h0));
    endtask

    task automatic test_security_access();
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h00, KEY_MASK, 32'h0));
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h01, 32'h0, 32'hFFFF_FFFF));
        send_item(mk_req(8'hFF, SVC_SECURITY, 8'hFE, 32'hFFFF_FFFF ^ KEY_MASK, 32'h0));
        send_item(mk_req(8'd5, SVC_SECURITY, 8'h02, 32'hFFFF_FFFF ^ KEY_MASK, 32'h0));
        send_item(mk_req(8'd1, SVC_SECURITY, 8'h01, 32'h0, 32'h0));
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h04, 32'h0, 32'h0));
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h04, 32'h0, 32'h0));
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h03, 32'h0, 32'hA5A5_5A5A));
    endtask

    task automatic test_timers();
        write_reg(CFG_SESSION_TIMEOUT, 16'd0);
        write_reg(CFG_LOCKOUT, 16'd2);
        send_item(mk_req(LEN_SESSION, SVC_SESSION, SESS_EXTENDED, 32'h0, 32'h0));
        send_item(mk_tick());
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h02, 32'h0, 32'h0));
        repeat (3) send_item(mk_tick());
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h01, 32'h0, 32'h1357_9BDF));
    endtask

    task automatic test_max_failures_zero();
        write_reg(CFG_MAX_FAILURES, 16'd0);
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h01, 32'h0, 32'h2468_ACE0));
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h02, 32'h0, 32'h0));
        send_item(mk_tick());
        send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h02, seed_held ^ KEY_MASK, 32'h0));
    endtask

    task automatic test_failure_saturation();
        write_reg(CFG_MAX_FAILURES, 16'd255);
        write_reg(CFG_LOCKOUT, 16'd3);
        repeat (258) send_item(mk_req(LEN_KEY_MIN, SVC_SECURITY, 8'h06, ~seed_held, 32'h0));
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h05, 32'h0, 32'h0));
        repeat (4) send_item(mk_tick());
        send_item(mk_req(LEN_SECURITY_MIN, SVC_SECURITY, 8'h05, 32'h0, 32'hCAFE_F00D));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SESSION_TIMEOUT, 16'd0);
                    write_reg(CFG_LOCKOUT, 16'hFFFF);
                    write_reg(CFG_MAX_FAILURES, 16'd1);
                end
                1: begin
                    write_reg(CFG_SESSION_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_LOCKOUT, 16'd0);
                    write_reg(CFG_MAX_FAILURES, 16'd255);
                end
                default: begin
                    write_reg(CFG_SESSION_TIMEOUT, 16'($urandom_range(0, 40)));
                    write_reg(CFG_LOCKOUT, 16'($urandom_range(0, 30)));
                    write_reg(CFG_MAX_FAILURES, 16'($urandom_range(1, 6)));
                end
            endcase
            write_reg(CFG_ENABLE_PROG, 16'($urandom_range(0, 1)));
            write_reg(CFG_ENABLE_EXT, 16'($urandom_range(0, 1)));
            write_reg(CFG_ENABLE_SAFETY, 16'($urandom_range(0, 1)));
            steady = (phase == 3 || phase == 4);
            repeat (90) send_item(random_request());
            steady = 1'b0;
        end
    endtask

    initial begin
        reset_session_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_session_control();
        test_security_access();
        test_timers();
        test_max_failures_zero();
        test_failure_saturation();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_status_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
